// ===== hdl/lmng_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmng_pkg: constants for the logistic map noise generator
// Field widths, fixed-point scaling and reset values shared by the block.
// ----------------------------------------------------------------------------
package lmng_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int R_W         = FRAC_BITS + 3;   // Q3.16 chaos parameter
  localparam int LEVEL_W     = FRAC_BITS + 1;   // Q0.16 level, 1.0 included
  localparam int FREQ_W      = 18;
  localparam int SR_W        = 18;
  localparam int CNT_W       = 28;

  // shift-add multiplier: multiplicand A, multiplier B consumed one bit a cycle
  localparam int MUL_A_W     = R_W;
  localparam int MUL_B_W     = LEVEL_W;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;

  localparam int IN_TDATA_W  = ((R_W + FREQ_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((LEVEL_W + 7) / 8) * 8;

  localparam logic [SR_W-1:0]    SR_RESET   = SR_W'(48000);
  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = LEVEL_W'(1) << FRAC_BITS;
  localparam logic [LEVEL_W-1:0] LEVEL_HALF = LEVEL_W'(1) << (FRAC_BITS - 1);

endpackage

// ===== hdl/logistic_map_noise_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logistic_map_noise_generator_top: sample-and-hold logistic map source
// One input transfer per audio tick; one output transfer with the held level.
// ----------------------------------------------------------------------------
// Each accepted tick returns the held level y (Q0.16). A 28-bit countdown
// sets how often y moves: when it is zero on a tick, y steps through
// y <- r*y*(1-y) (saturated to 1.0) and the countdown reloads with
// floor(sample_rate / freq) - 1, where freq is clamped to sample_rate and a
// zero freq means 0.001 Hz (period sample_rate*1000). A tick that only
// decrements the countdown goes straight to the done state, which loads
// the held level into the output register and returns to idle.
// A reloading tick runs the shared shift-add multiplier twice (one
// multiplier bit per cycle) and then the restoring divider (one quotient
// bit per cycle); the divide is skipped when the clamped freq is zero.
// The result sits in an output register, so the next tick is taken while
// it waits to be read; a new result is not loaded until the previous one
// has been transferred, and the block holds in the done state meanwhile.
// sample_rate is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while the block is idle (not enforced by the block); it resets to 48000.
// ----------------------------------------------------------------------------
module logistic_map_noise_generator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // config: sample_rate
  input  logic                                cfg_wr_en,
  input  logic [lmng_pkg::SR_W-1:0]           cfg_wr_data,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lmng_pkg::IN_TDATA_W-1:0]     in_tdata,   // [18:0] r coeff, [36:19] freq_hz
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lmng_pkg::OUT_TDATA_W-1:0]    out_tdata   // [16:0] level
);
  import lmng_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,   // t = y * (1 - y)
    S_MUL2,   // v = r * t
    S_DIV,    // period = sample_rate / freq
    S_DONE
  } state_t;

  localparam int BIT_CNT_W = $clog2(SR_W > MUL_B_W ? SR_W : MUL_B_W);

  state_t                 state_r;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [SR_W-1:0]        sample_rate_r;
  logic [LEVEL_W-1:0]     held_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [BIT_CNT_W-1:0]   bit_cnt_r;

  // datapath
  logic [R_W-1:0]         r_r;
  logic [FREQ_W-1:0]      fc_r;       // clamped frequency
  logic [MUL_A_W-1:0]     mcand_r;
  logic [PROD_W-1:0]      prod_r;
  logic [SR_W-1:0]        dq_r;       // dividend in, quotient out
  logic [SR_W-1:0]        rem_r;

  logic                   in_xfer;
  logic                   out_load;
  logic [R_W-1:0]         in_rcoef;
  logic [FREQ_W-1:0]      in_freq;
  logic [LEVEL_W-1:0]     y_sat;
  logic [LEVEL_W-1:0]     one_minus_y;
  logic [MUL_A_W:0]       mul_sum;
  logic [PROD_W-1:0]      prod_nxt;
  logic [LEVEL_W-1:0]     t_val;
  logic [PROD_W-FRAC_BITS-1:0] v_val;
  logic [LEVEL_W-1:0]     v_sat;
  logic [SR_W+1:0]        div_diff;
  logic                   div_borrow;
  logic [SR_W-1:0]        rem_nxt;
  logic [SR_W-1:0]        dq_nxt;
  logic [CNT_W-1:0]       sr_ext;
  logic [CNT_W-1:0]       milli_period;
  logic [CNT_W-1:0]       milli_cnt;
  logic [CNT_W-1:0]       div_cnt;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign in_rcoef   = in_tdata[R_W-1:0];
  assign in_freq    = in_tdata[R_W+FREQ_W-1:R_W];
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // result goes into the output register once it is free or being read
  assign out_load   = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // map operands
  assign y_sat       = (held_r > LEVEL_ONE) ? LEVEL_ONE : held_r;
  assign one_minus_y = LEVEL_ONE - y_sat;

  // one shift-add step: add multiplicand on the low multiplier bit, shift right
  assign mul_sum  = {1'b0, prod_r[PROD_W-1:MUL_B_W]} +
                    (prod_r[0] ? {1'b0, mcand_r} : '0);
  assign prod_nxt = {mul_sum, prod_r[MUL_B_W-1:1]};
  assign t_val    = prod_nxt[FRAC_BITS+LEVEL_W-1:FRAC_BITS];
  assign v_val    = prod_nxt[PROD_W-1:FRAC_BITS];
  assign v_sat    = (v_val > {{(PROD_W-FRAC_BITS-LEVEL_W){1'b0}}, LEVEL_ONE}) ?
                    LEVEL_ONE : v_val[LEVEL_W-1:0];

  // one restoring divide step
  assign div_diff   = {1'b0, rem_r, dq_r[SR_W-1]} - {2'b0, fc_r};
  assign div_borrow = div_diff[SR_W+1];
  assign rem_nxt    = div_borrow ? {rem_r[SR_W-2:0], dq_r[SR_W-1]} : div_diff[SR_W-1:0];
  assign dq_nxt     = {dq_r[SR_W-2:0], ~div_borrow};
  assign div_cnt    = (dq_nxt == '0) ? '0 : CNT_W'(dq_nxt) - CNT_W'(1);

  // zero frequency: period = sample_rate * 1000 = (x<<10) - (x<<5) + (x<<3)
  assign sr_ext       = CNT_W'(sample_rate_r);
  assign milli_period = (sr_ext << 10) - (sr_ext << 5) + (sr_ext << 3);
  assign milli_cnt    = (milli_period == '0) ? '0 : milli_period - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_tvalid_r  <= 1'b0;
      sample_rate_r <= SR_RESET;
      held_r        <= LEVEL_HALF;
      cnt_r         <= '0;
      bit_cnt_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        sample_rate_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            r_r  <= in_rcoef;
            fc_r <= (in_freq > sample_rate_r) ? sample_rate_r : in_freq;
            if (cnt_r == '0) begin
              mcand_r   <= MUL_A_W'(y_sat);
              prod_r    <= PROD_W'(one_minus_y);
              bit_cnt_r <= '0;
              state_r   <= S_MUL1;
            end else begin
              cnt_r   <= cnt_r - CNT_W'(1);
              state_r <= S_DONE;
            end
          end
        end

        S_MUL1: begin
          if (bit_cnt_r == BIT_CNT_W'(MUL_B_W - 1)) begin
            mcand_r   <= r_r;
            prod_r    <= PROD_W'(t_val);
            bit_cnt_r <= '0;
            state_r   <= S_MUL2;
          end else begin
            bit_cnt_r <= bit_cnt_r + 1'b1;
            prod_r    <= prod_nxt;
          end
        end

        S_MUL2: begin
          prod_r <= prod_nxt;
          if (bit_cnt_r == BIT_CNT_W'(MUL_B_W - 1)) begin
            held_r    <= v_sat;
            bit_cnt_r <= '0;
            if (fc_r == '0) begin
              cnt_r   <= milli_cnt;
              state_r <= S_DONE;
            end else begin
              dq_r    <= sample_rate_r;
              rem_r   <= '0;
              state_r <= S_DIV;
            end
          end else begin
            bit_cnt_r <= bit_cnt_r + 1'b1;
          end
        end

        S_DIV: begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
          if (bit_cnt_r == BIT_CNT_W'(SR_W - 1)) begin
            cnt_r     <= div_cnt;
            bit_cnt_r <= '0;
            state_r   <= S_DONE;
          end else begin
            bit_cnt_r <= bit_cnt_r + 1'b1;
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_tdata_r <= OUT_TDATA_W'(held_r);
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // held level never leaves 0..1.0
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= LEVEL_ONE)
    else $error("held level above 1.0");

  // a tick with a running countdown only decrements it
  a_cnt_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && cnt_r != '0) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)) && (state_r == S_DONE))
    else $error("countdown not decremented");

  // a tick with an expired countdown starts the map step
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && cnt_r == '0) |=> (state_r == S_MUL1) && (bit_cnt_r == '0))
    else $error("reload did not start map step");

  // the divider never runs past the dividend width
  a_div_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (bit_cnt_r < BIT_CNT_W'(SR_W)))
    else $error("divider bit count overrun");

endmodule
